// ===== sv/bps_pkg.sv =====
`default_nettype none
package bps_pkg;
  localparam int PosW = 24;
  localparam int DtW = 16;
  localparam int CfgIdxW = 3;
  localparam int CfgDataW = 24;
  localparam int MIN_SPEED_DEF = 0;
  localparam int MinSpeedW = 16;

  typedef enum logic [1:0] {
    MODE_TICK = 2'd0,
    MODE_SET_POS = 2'd1,
    MODE_SET_VEL = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GRAVITY = 3'd0,
    REG_ELASTICITY = 3'd1,
    REG_FRICTION = 3'd2,
    REG_LEFT = 3'd3,
    REG_RIGHT = 3'd4,
    REG_BOTTOM = 3'd5,
    REG_TOP = 3'd6,
    REG_MAX_SPEED = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [DtW-1:0] time_step;
    logic signed [PosW-1:0] value_x;
    logic signed [PosW-1:0] value_y;
  } in_item_t;

  typedef struct packed {
    logic signed [PosW-1:0] pos_x_out;
    logic signed [PosW-1:0] pos_y_out;
    logic signed [PosW-1:0] vel_x_out;
    logic signed [PosW-1:0] vel_y_out;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_item_t;

  // saturate a wide signed value to 24 bits
  function automatic logic signed [PosW-1:0] sat24(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = 48'sd8388607;
    lo = -48'sd8388608;
    if (v > hi) sat24 = 24'sh7FFFFF;
    else if (v < lo) sat24 = 24'sh800000;
    else sat24 = v[PosW-1:0];
  endfunction
endpackage
`default_nettype wire

// ===== sv/bps_if.sv =====
`default_nettype none
interface bps_if #(parameter int W = 8);
  logic valid;
  logic ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/bouncing_particle_step_top.sv =====
`default_nettype none
// Bouncing particle step. Holds one particle's position and velocity (signed
// Q15.8, y up) and answers every request with one result showing the state
// after it. Mode 0 ticks by a Q0.16 time step: gravity with a rest snap near
// the floor, integration, speed colour, then at most one wall bounce. Modes 1
// and 2 load position or velocity; mode 3 changes nothing. A set request's
// result is valid in the cycle after the request is taken. A tick runs on one
// shared 25x25 multiplier under a small sequencer: a state each for g*dt,
// gravity, the two integrations and the two squares, 24 square root steps,
// a clamp state, then, unless the speed span is empty, three quadrant
// steps, one scale, eight divide steps and a paint state, and last a wall
// check, followed on a bounce by the updates of both velocity parts. No
// request is taken while a tick runs or a result waits; the next request can
// be taken in the cycle after the result is.
module bouncing_particle_step_top
  import bps_pkg::*;
#(
  parameter int MIN_SPEED = MIN_SPEED_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_data,
  bps_if.sink   in_ch,
  bps_if.source out_ch
);
  typedef enum logic [3:0] {
    S_IDLE, S_GDT, S_GRAV, S_IX, S_IY, S_SQX, S_SQY, S_SQRT, S_COL, S_QUAD,
    S_SCALE, S_DIV, S_PAINT, S_WALL, S_W1, S_W2
  } st_t;

  st_t st_r;
  in_item_t req;
  logic [DtW-1:0] dt_r;
  logic [19:0] grav_r;
  logic [16:0] elas_r, fric_r;
  logic signed [23:0] left_r, right_r, bot_r, top_r;
  logic [22:0] maxs_r;
  logic signed [23:0] px_r, py_r, vx_r, vy_r;
  logic [7:0] cr_r, cg_r, cb_r;
  logic [47:0] sq_r, rem_r, root_r;
  logic [4:0] cnt_r;
  logic wall_x_r;
  logic [1:0] quad_r;
  logic [24:0] num_r;
  logic [31:0] div_r;
  logic [7:0] q_r;
  logic out_v_r;

  logic signed [24:0] alu_a;
  logic [23:0] alu_b;
  logic [4:0] alu_sh;
  logic signed [47:0] prod;

  logic [23:0] ax, ay;
  logic [22:0] mn, d, sp, n, r_sel;
  logic signed [47:0] gsum, g20, v19;
  logic snap;
  logic [47:0] bit_v, trial;
  logic [31:0] dsh;
  logic hit_l, hit_r, hit_b, hit_t, hit_x;

  bps_alu u_alu (.clk(clk), .a(alu_a), .b(alu_b), .shift(alu_sh), .prod_r(prod));

  assign req = in_item_t'(in_ch.data);

  assign ax = vx_r[23] ? 24'(-25'(vx_r)) : 24'(vx_r);
  assign ay = vy_r[23] ? 24'(-25'(vy_r)) : 24'(vy_r);

  assign mn = 23'(MIN_SPEED);
  assign d = maxs_r - mn;
  assign sp = (root_r > 48'(maxs_r)) ? maxs_r : ((root_r < 48'(mn)) ? mn : root_r[22:0]);
  assign n = sp - mn;
  assign r_sel = quad_r[0] ? (d - num_r[22:0]) : num_r[22:0];

  // rest snap uses the exact wide sum; prod holds g*dt in S_GRAV
  assign gsum = 48'(py_r) + 48'(vy_r) - prod;
  assign g20 = 48'sd20 * prod;
  assign v19 = 48'sd19 * (-48'(vy_r));
  assign snap = vy_r[23] && (gsum < 48'(bot_r)) && (g20 > v19);

  assign bit_v = 48'd1 << {cnt_r, 1'b0};
  assign trial = root_r + bit_v;
  assign dsh = 32'(d) << cnt_r[2:0];

  assign hit_l = px_r < left_r;
  assign hit_r = px_r > right_r;
  assign hit_b = py_r < bot_r;
  assign hit_t = py_r > top_r;
  assign hit_x = hit_l || hit_r;

  // operand select for the multiplier; the product is read one state later
  always_comb begin
    alu_a = '0;
    alu_b = '0;
    alu_sh = 5'd16;
    unique case (st_r)
      S_GDT:  begin alu_a = signed'({5'b0, grav_r}); alu_b = 24'(dt_r); end
      S_GRAV: begin alu_a = 25'(vx_r); alu_b = 24'(dt_r); end
      S_IX:   begin alu_a = 25'(vy_r); alu_b = 24'(dt_r); end
      S_IY:   begin alu_a = signed'({1'b0, ax}); alu_b = ax; alu_sh = 5'd0; end
      S_SQX:  begin alu_a = signed'({1'b0, ay}); alu_b = ay; alu_sh = 5'd0; end
      S_WALL: begin alu_a = hit_x ? -25'(vx_r) : -25'(vy_r); alu_b = 24'(elas_r); end
      S_W1:   begin alu_a = wall_x_r ? 25'(vy_r) : 25'(vx_r); alu_b = 24'(fric_r); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_v_r <= 1'b0;
      grav_r <= 20'd128000; elas_r <= 17'd52429; fric_r <= 17'd62259;
      left_r <= '0; right_r <= 24'sd204800; bot_r <= '0; top_r <= 24'sd153600;
      maxs_r <= 23'd256000;
      px_r <= '0; py_r <= '0; vx_r <= '0; vy_r <= '0;
      cr_r <= '0; cg_r <= '0; cb_r <= 8'hFF;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_GRAVITY:    grav_r <= cfg_data[19:0];
          REG_ELASTICITY: elas_r <= cfg_data[16:0];
          REG_FRICTION:   fric_r <= cfg_data[16:0];
          REG_LEFT:       left_r <= cfg_data;
          REG_RIGHT:      right_r <= cfg_data;
          REG_BOTTOM:     bot_r <= cfg_data;
          REG_TOP:        top_r <= cfg_data;
          REG_MAX_SPEED:  maxs_r <= cfg_data[22:0];
          default: ;
        endcase
      end
      unique case (st_r)
        S_IDLE: begin
          if (out_v_r) begin
            if (out_ch.ready) out_v_r <= 1'b0;
          end else if (in_ch.valid) begin
            dt_r <= req.time_step;
            unique case (mode_t'(req.mode))
              MODE_TICK: st_r <= S_GDT;
              MODE_SET_POS: begin
                px_r <= req.value_x; py_r <= req.value_y; out_v_r <= 1'b1;
              end
              MODE_SET_VEL: begin
                vx_r <= req.value_x; vy_r <= req.value_y; out_v_r <= 1'b1;
              end
              default: out_v_r <= 1'b1;
            endcase
          end
        end
        S_GDT: st_r <= S_GRAV;
        S_GRAV: begin
          if (snap) begin
            vy_r <= '0; py_r <= bot_r;
          end else if (vy_r != '0) vy_r <= sat24(48'(vy_r) - prod);
          st_r <= S_IX;
        end
        S_IX: begin px_r <= sat24(48'(px_r) + prod); st_r <= S_IY; end
        S_IY: begin py_r <= sat24(48'(py_r) + prod); st_r <= S_SQX; end
        S_SQX: begin sq_r <= prod; st_r <= S_SQY; end
        S_SQY: begin
          rem_r <= sq_r + prod; root_r <= '0; cnt_r <= 5'd23; st_r <= S_SQRT;
        end
        S_SQRT: begin
          if (rem_r >= trial) begin
            rem_r <= rem_r - trial;
            root_r <= (root_r >> 1) + bit_v;
          end else begin
            root_r <= root_r >> 1;
          end
          if (cnt_r == 5'd0) st_r <= S_COL;
          else cnt_r <= cnt_r - 5'd1;
        end
        S_COL: begin
          if (maxs_r <= mn) begin
            cr_r <= 8'hFF; cg_r <= 8'h00; cb_r <= 8'h00; st_r <= S_WALL;
          end else begin
            num_r <= {n, 2'b00}; quad_r <= 2'd0; cnt_r <= 5'd0; st_r <= S_QUAD;
          end
        end
        S_QUAD: begin
          // three compare-subtract steps give the quarter and its remainder
          if (num_r >= 25'(d)) begin
            num_r <= num_r - 25'(d); quad_r <= quad_r + 2'd1;
          end
          if (cnt_r == 5'd2) st_r <= S_SCALE;
          cnt_r <= cnt_r + 5'd1;
        end
        S_SCALE: begin
          // 255*r on rising quarters, 255*(d-r) on falling ones
          div_r <= {1'b0, r_sel, 8'h00} - 32'(r_sel);
          q_r <= '0; cnt_r <= 5'd7; st_r <= S_DIV;
        end
        S_DIV: begin
          if (div_r >= dsh) begin
            div_r <= div_r - dsh;
            q_r <= q_r | (8'd1 << cnt_r[2:0]);
          end
          if (cnt_r == 5'd0) st_r <= S_PAINT;
          else cnt_r <= cnt_r - 5'd1;
        end
        S_PAINT: begin
          case (quad_r)
            2'd0: begin cr_r <= 8'h00; cg_r <= q_r; cb_r <= 8'hFF; end
            2'd1: begin cr_r <= 8'h00; cg_r <= 8'hFF; cb_r <= q_r; end
            2'd2: begin cr_r <= q_r; cg_r <= 8'hFF; cb_r <= 8'h00; end
            default: begin cr_r <= 8'hFF; cg_r <= q_r; cb_r <= 8'h00; end
          endcase
          st_r <= S_WALL;
        end
        S_WALL: begin
          wall_x_r <= hit_x;
          if (hit_l) begin
            px_r <= sat24(48'(left_r) + 48'sd256); st_r <= S_W1;
          end else if (hit_r) begin
            px_r <= sat24(48'(right_r) - 48'sd256); st_r <= S_W1;
          end else if (hit_b) begin
            py_r <= sat24(48'(bot_r) + 48'sd256); st_r <= S_W1;
          end else if (hit_t) begin
            py_r <= sat24(48'(top_r) - 48'sd256); st_r <= S_W1;
          end else begin
            out_v_r <= 1'b1; st_r <= S_IDLE;
          end
        end
        S_W1: begin
          if (wall_x_r) vx_r <= sat24(prod);
          else vy_r <= sat24(prod);
          st_r <= S_W2;
        end
        S_W2: begin
          if (wall_x_r) vy_r <= sat24(prod);
          else vx_r <= sat24(prod);
          out_v_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready = (st_r == S_IDLE) && !out_v_r;
  assign out_ch.valid = out_v_r;
  assign out_ch.data = {px_r, py_r, vx_r, vy_r, cr_r, cg_r, cb_r};
endmodule
`default_nettype wire

// ===== sv/bps_alu.sv =====
`default_nettype none
// Shared unit: one signed multiply with a floor shift, result registered.
module bps_alu
  import bps_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic signed [24:0]   a,
  input  wire logic [23:0]          b,
  input  wire logic [4:0]           shift,
  output logic signed [47:0]        prod_r
);
  logic signed [49:0] p;
  assign p = a * $signed({1'b0, b});
  always_ff @(posedge clk) begin
    prod_r <= 48'(p >>> shift);
  end
endmodule
`default_nettype wire
